// File: src/drs_pkg.sv
package drs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int NUM_DIGITS = 7;
  localparam int RADIX      = 10;
  localparam int BIN_W      = 24;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int POS_W      = $clog2(NUM_DIGITS);
  localparam int DIG_W      = 4;
  localparam int STEP_W     = $clog2(BIN_W);

  localparam logic [BIN_W-1:0] MAX_VALUE = BIN_W'(10 ** NUM_DIGITS - 1);

  typedef struct packed {
    logic [BIN_W-1:0] item_value;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] sorted_value;
    logic             last_out;
    logic             overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CONV,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_OUT_RD,
    ST_OUT_LATCH,
    ST_OUT_CV,
    ST_OUT_HOLD
  } state_t;

endpackage

// File: src/drs_bin2bcd.sv
module drs_bin2bcd
  import drs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin_in,
  output logic             done,
  output logic [BCD_W-1:0] bcd_out
);

  logic [BIN_W-1:0]  sh_r, sh_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, adj;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // add 3 to every digit of 5 or more, then shift one binary bit in
  always_comb begin
    adj = bcd_r;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = bin_in;
      bcd_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt   = {sh_r[BIN_W-2:0], 1'b0};
      bcd_nxt  = {adj[BCD_W-2:0], sh_r[BIN_W-1]};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(BIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done    = done_r;
  assign bcd_out = bcd_r;

endmodule

// File: src/decimal_radix_sorter.sv
// channel | ports                         | direction
// input   | in_valid  in_ready  in_data   | item to sort, is_last closes the set
// result  | out_valid out_ready out_data  | sorted items, ascending
//
// Loading an item: accept it, run 24 steps of the binary-to-decimal shifter,
// then write it to the store.
// The sort makes 7 digit passes over the store, each with the steps
// clear, count, prefix over 10 buckets and scatter.
// Each result is read, latched and rebuilt in 7 multiply-by-ten steps, then held while stalled.
// Reset (rst_n low, synchronous) empties the set; no clearing pass is needed.
// A stall on the result side holds the block; no input is taken until the run ends.
module decimal_radix_sorter
  import drs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              last_pend_r, last_pend_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  pass_r, pass_nxt;
  logic              bank_r, bank_nxt;
  logic              rv_r, rv_nxt;
  logic [CNT_W-1:0]  cnt_r [RADIX];
  logic [CNT_W-1:0]  cnt_nxt [RADIX];
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [BIN_W-1:0]  acc_r, acc_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  out_item_t         out_r, out_nxt;

  logic [BCD_W-1:0]  mem0 [MAX_ITEMS];
  logic [BCD_W-1:0]  mem1 [MAX_ITEMS];
  logic [BCD_W-1:0]  rd0_r, rd1_r, rdata;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [BCD_W-1:0]  wr_data;
  logic              we0, we1;

  logic              conv_start, conv_done;
  logic [BIN_W-1:0]  conv_in;
  logic [BCD_W-1:0]  conv_bcd;
  logic [DIG_W-1:0]  digit;
  logic [BIN_W-1:0]  acc_step;

  drs_bin2bcd u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (conv_start),
    .bin_in  (conv_in),
    .done    (conv_done),
    .bcd_out (conv_bcd)
  );

  assign conv_in  = (in_data.item_value > MAX_VALUE) ? MAX_VALUE : in_data.item_value;
  assign rdata    = bank_r ? rd1_r : rd0_r;
  assign digit    = rdata[{pass_r, 2'b00} +: DIG_W];
  assign acc_step = (acc_r << 3) + (acc_r << 1) + BIN_W'(bcd_r[{k_r, 2'b00} +: DIG_W]);

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT_HOLD);
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_pend_nxt = last_pend_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    bank_nxt      = bank_r;
    rv_nxt        = 1'b0;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    bcd_nxt       = bcd_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    rd_addr       = idx_r[ADDR_W-1:0];
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = conv_bcd;
    we0           = 1'b0;
    we1           = 1'b0;
    conv_start    = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          last_pend_nxt = in_data.is_last;
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            conv_start = 1'b1;
            state_nxt  = ST_CONV;
          end else begin
            ovf_nxt = 1'b1;
            if (in_data.is_last) begin
              state_nxt = ST_CLEAR;
            end
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          we0       = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = last_pend_r ? ST_CLEAR : ST_LOAD;
        end
      end
      ST_CLEAR: begin
        for (int d = 0; d < RADIX; d++) begin
          cnt_nxt[d] = '0;
        end
        idx_nxt   = '0;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (idx_r < count_r) begin
          idx_nxt = idx_r + 1'b1;
          rv_nxt  = 1'b1;
        end
        if (rv_r && digit < DIG_W'(RADIX)) begin
          cnt_nxt[digit] = cnt_r[digit] + 1'b1;
        end
        if (idx_r == count_r && !rv_r) begin
          idx_nxt   = '0;
          run_nxt   = '0;
          state_nxt = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        // turn counts into start offsets, one bucket a cycle
        cnt_nxt[idx_r[DIG_W-1:0]] = run_r;
        run_nxt = run_r + cnt_r[idx_r[DIG_W-1:0]];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CNT_W'(RADIX - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_SCATTER;
        end
      end
      ST_SCATTER: begin
        if (idx_r < count_r) begin
          idx_nxt = idx_r + 1'b1;
          rv_nxt  = 1'b1;
        end
        if (rv_r && digit < DIG_W'(RADIX)) begin
          wr_addr        = cnt_r[digit][ADDR_W-1:0];
          wr_data        = rdata;
          we0            = bank_r;
          we1            = !bank_r;
          cnt_nxt[digit] = cnt_r[digit] + 1'b1;
        end
        if (idx_r == count_r && !rv_r) begin
          bank_nxt = !bank_r;
          idx_nxt  = '0;
          if (pass_r == POS_W'(NUM_DIGITS - 1)) begin
            pass_nxt  = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LATCH;
      end
      ST_OUT_LATCH: begin
        bcd_nxt   = rdata;
        acc_nxt   = '0;
        k_nxt     = POS_W'(NUM_DIGITS - 1);
        state_nxt = ST_OUT_CV;
      end
      ST_OUT_CV: begin
        acc_nxt = acc_step;
        k_nxt   = k_r - 1'b1;
        if (k_r == '0) begin
          out_nxt.sorted_value = acc_step;
          out_nxt.last_out     = (idx_r + 1'b1 == count_r);
          out_nxt.overflowed   = ovf_r;
          state_nxt            = ST_OUT_HOLD;
        end
      end
      ST_OUT_HOLD: begin
        if (out_ready) begin
          if (out_r.last_out) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            bank_nxt  = 1'b0;
            idx_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_pend_r <= 1'b0;
      idx_r       <= '0;
      pass_r      <= '0;
      bank_r      <= 1'b0;
      rv_r        <= 1'b0;
      run_r       <= '0;
      k_r         <= '0;
      for (int d = 0; d < RADIX; d++) begin
        cnt_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      last_pend_r <= last_pend_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      bank_r      <= bank_nxt;
      rv_r        <= rv_nxt;
      run_r       <= run_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wr_data;
    end
    if (we1) begin
      mem1[wr_addr] <= wr_data;
    end
    rd0_r <= mem0[rd_addr];
    rd1_r <= mem1[rd_addr];
  end

endmodule

// File: src/drs_checker.sv
module drs_checker
  import drs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is shown");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_out |=> !in_ready)
    else $error("input reopened before final result");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_out |=> in_ready)
    else $error("block not ready after final result");

endmodule

bind decimal_radix_sorter drs_checker u_drs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/decimal_radix_sorter_tb.sv
module decimal_radix_sorter_tb;
  import drs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  decimal_radix_sorter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  in_item_t   pending_items[$];
  out_item_t  sorted_expect[$];
  logic [BIN_W-1:0] held_values[$];
  logic       set_overflow;
  int         error_count = 0;
  int         cycle_count = 0;
  bit         quiet_phase = 0;
  bit         sender_pause = 0;
  int         out_hold_cycles = 0;
  int         in_gap = 0;
  int         out_gap = 0;

  // Add one accepted item to the running set; on the closing item, sort it.
  task automatic absorb_item(input in_item_t it);
    logic [BIN_W-1:0] v;
    logic [BIN_W-1:0] tmp;
    out_item_t r;
    int n;
    v = (it.item_value > MAX_VALUE) ? MAX_VALUE : it.item_value;
    if (held_values.size() < MAX_ITEMS) held_values.push_back(v);
    else set_overflow = 1'b1;
    if (it.is_last) begin
      n = held_values.size();
      for (int i = 1; i < n; i++)
        for (int j = i; j > 0 && held_values[j-1] > held_values[j]; j--) begin
          tmp = held_values[j];
          held_values[j] = held_values[j-1];
          held_values[j-1] = tmp;
        end
      for (int i = 0; i < n; i++) begin
        r.sorted_value = held_values[i];
        r.last_out = (i == n - 1);
        r.overflowed = set_overflow;
        sorted_expect.push_back(r);
      end
      held_values.delete();
      set_overflow = 1'b0;
    end
  endtask

  function automatic logic [BIN_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: rand_value = BIN_W'($urandom_range(0, 9));
      1: rand_value = BIN_W'($urandom_range(0, 999));
      2: rand_value = BIN_W'($urandom_range(0, 9999999));
      3: rand_value = BIN_W'(10 ** $urandom_range(0, 6));
      4: rand_value = BIN_W'($urandom());
      default: rand_value = BIN_W'($urandom_range(0, 99999));
    endcase
  endfunction

  task automatic queue_set(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.item_value = rand_value();
      it.is_last = (i == n - 1);
      pending_items.push_back(it);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) absorb_item(in_data);
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet_phase && !in_valid && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(1, 13);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !sender_pause) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (sorted_expect.size() == 0) begin
          $error("unexpected result sorted_value=%0d", out_data.sorted_value);
          error_count++;
        end else begin
          out_item_t e;
          e = sorted_expect.pop_front();
          if (out_data.sorted_value !== e.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", e.sorted_value,
                   out_data.sorted_value);
            error_count++;
          end
          if (out_data.last_out !== e.last_out) begin
            $error("last_out: expected %0b, got %0b", e.last_out, out_data.last_out);
            error_count++;
          end
          if (out_data.overflowed !== e.overflowed) begin
            $error("overflowed: expected %0b, got %0b", e.overflowed,
                   out_data.overflowed);
            error_count++;
          end
        end
      end
      if (out_hold_cycles > 0) begin
        out_hold_cycles <= out_hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_radix_sorter_tb: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || sorted_expect.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int n;
    logic [BIN_W-1:0] directed_vals[11];
    held_values = {};
    set_overflow = 1'b0;
    directed_vals = '{24'd9999999, 24'hFFFFFF, 24'd0, 24'd10, 24'd9, 24'd1000000,
                      24'd10000000, 24'd5, 24'd5, 24'd100, 24'd99};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single item, zero, extremes, saturation, ties, digit-length mix
    it.item_value = '0; it.is_last = 1'b1; pending_items.push_back(it);
    foreach (directed_vals[i]) begin
      it.item_value = directed_vals[i];
      it.is_last = (i == 10);
      pending_items.push_back(it);
    end
    it.item_value = 24'h555555; it.is_last = 1'b0; pending_items.push_back(it);
    it.item_value = 24'hAAAAAA; it.is_last = 1'b1; pending_items.push_back(it);
    wait_drained();

    // overflow: fill the store and keep going, closing item dropped too
    for (int i = 0; i < MAX_ITEMS + 3; i++) begin
      it.item_value = BIN_W'($urandom_range(0, 9999999));
      it.is_last = (i == MAX_ITEMS + 2);
      pending_items.push_back(it);
    end
    // hold the result side while the sender keeps offering the next set
    queue_set(5);
    while (!out_valid) @(posedge clk);
    out_hold_cycles = 400;
    wait_drained();

    // sender pause until the outstanding results are all back
    queue_set(6);
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    sender_pause = 1;
    queue_set(4);
    while (sorted_expect.size() > 0) @(posedge clk);
    sender_pause = 0;
    wait_drained();

    for (int total = 0; total < 130; total += n) begin
      n = ($urandom_range(0, 9) == 0) ? MAX_ITEMS : $urandom_range(1, 8);
      queue_set(n);
    end
    while (pending_items.size() > 30) @(posedge clk);
    quiet_phase = 1;
    wait_drained();
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("decimal_radix_sorter_tb: clean");
    end else begin
      $display("decimal_radix_sorter_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/drs_pkg.sv
src/drs_bin2bcd.sv
src/decimal_radix_sorter.sv
src/drs_checker.sv
tb/decimal_radix_sorter_tb.sv
